// File: rtl/core/bounded_table_engine_defines.svh
// Assertion macros used by the table engine datapath RTL.
`ifndef BOUNDED_TABLE_ENGINE_DEFINES_SVH
`define BOUNDED_TABLE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define BTE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("bte assertion failed");
// Check that a trigger is followed by a consequence in the next cycle.
`define BTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bte assertion failed");
`else
`define BTE_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define BTE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/bte_pkg.sv
// Package with action, status and datapath command codes of the table engine.
package bte_pkg;

    localparam logic [3:0] ACT_CLEAR    = 4'd0;
    localparam logic [3:0] ACT_ADD      = 4'd1;
    localparam logic [3:0] ACT_DELFIRST = 4'd2;
    localparam logic [3:0] ACT_DELALL   = 4'd3;
    localparam logic [3:0] ACT_SEARCH   = 4'd4;
    localparam logic [3:0] ACT_COUNT    = 4'd5;
    localparam logic [3:0] ACT_SUM      = 4'd6;
    localparam logic [3:0] ACT_MAX      = 4'd7;
    localparam logic [3:0] ACT_MIN      = 4'd8;
    localparam logic [3:0] ACT_MODE     = 4'd9;
    localparam logic [3:0] ACT_SORTUP   = 4'd10;
    localparam logic [3:0] ACT_SORTDN   = 4'd11;
    localparam logic [3:0] ACT_READ     = 4'd12;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    typedef logic [3:0] t_dp_cmd;

    localparam t_dp_cmd DP_NOP        = 4'd0;
    localparam t_dp_cmd DP_LOAD       = 4'd1;
    localparam t_dp_cmd DP_APPLY      = 4'd2;
    localparam t_dp_cmd DP_RD_I       = 4'd3;
    localparam t_dp_cmd DP_SCAN       = 4'd4;
    localparam t_dp_cmd DP_MODE_KEY   = 4'd5;
    localparam t_dp_cmd DP_RD_J       = 4'd6;
    localparam t_dp_cmd DP_MODE_CNT   = 4'd7;
    localparam t_dp_cmd DP_MODE_NEXT  = 4'd8;
    localparam t_dp_cmd DP_SORT_KEY   = 4'd9;
    localparam t_dp_cmd DP_RD_JM1     = 4'd10;
    localparam t_dp_cmd DP_SORT_CMP   = 4'd11;
    localparam t_dp_cmd DP_SORT_PLACE = 4'd12;
    localparam t_dp_cmd DP_RD_POS     = 4'd13;
    localparam t_dp_cmd DP_READ_EV    = 4'd14;
    localparam t_dp_cmd DP_FINISH     = 4'd15;

    typedef struct packed {
        logic [3:0] act;
        logic       i_end;
        logic       j_end;
        logic       j_zero;
        logic       sort_shift;
        logic       pos_ok;
        logic       out_free;
    } t_dp_sts;

endpackage

// File: rtl/core/bte_ram.sv
// Generic single write port, single read port RAM with registered read data.
module bte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/bte_ctrl.sv
// Sequencer that steps the table datapath through each action.
module bte_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bte_pkg::t_dp_sts  i_sts,
    output bte_pkg::t_dp_cmd  o_cmd
);
    import bte_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_SCAN_RD = 4'd2;
    localparam logic [3:0] S_SCAN_EV = 4'd3;
    localparam logic [3:0] S_MKEY_RD = 4'd4;
    localparam logic [3:0] S_MKEY_EV = 4'd5;
    localparam logic [3:0] S_MCNT_RD = 4'd6;
    localparam logic [3:0] S_MCNT_EV = 4'd7;
    localparam logic [3:0] S_SKEY_RD = 4'd8;
    localparam logic [3:0] S_SKEY_EV = 4'd9;
    localparam logic [3:0] S_SCMP_RD = 4'd10;
    localparam logic [3:0] S_SCMP_EV = 4'd11;
    localparam logic [3:0] S_READ_RD = 4'd12;
    localparam logic [3:0] S_READ_EV = 4'd13;
    localparam logic [3:0] S_FIN     = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and datapath command
    always_comb begin
        n_state = r_state;
        o_cmd   = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = DP_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.act) inside
                    ACT_DELFIRST, ACT_DELALL, ACT_SEARCH, ACT_COUNT,
                    ACT_SUM, ACT_MAX, ACT_MIN: n_state = S_SCAN_RD;
                    ACT_MODE:                  n_state = S_MKEY_RD;
                    ACT_SORTUP, ACT_SORTDN:    n_state = S_SKEY_RD;
                    ACT_READ:                  n_state = S_READ_RD;
                    default: begin
                        o_cmd   = DP_APPLY;
                        n_state = S_FIN;
                    end
                endcase
            end
            S_SCAN_RD: begin
                if (i_sts.i_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd   = DP_RD_I;
                    n_state = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                o_cmd   = DP_SCAN;
                n_state = S_SCAN_RD;
            end
            S_MKEY_RD: begin
                if (i_sts.i_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd   = DP_RD_I;
                    n_state = S_MKEY_EV;
                end
            end
            S_MKEY_EV: begin
                o_cmd   = DP_MODE_KEY;
                n_state = S_MCNT_RD;
            end
            S_MCNT_RD: begin
                if (i_sts.j_end) begin
                    o_cmd   = DP_MODE_NEXT;
                    n_state = S_MKEY_RD;
                end else begin
                    o_cmd   = DP_RD_J;
                    n_state = S_MCNT_EV;
                end
            end
            S_MCNT_EV: begin
                o_cmd   = DP_MODE_CNT;
                n_state = S_MCNT_RD;
            end
            S_SKEY_RD: begin
                if (i_sts.i_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd   = DP_RD_I;
                    n_state = S_SKEY_EV;
                end
            end
            S_SKEY_EV: begin
                o_cmd   = DP_SORT_KEY;
                n_state = S_SCMP_RD;
            end
            S_SCMP_RD: begin
                if (i_sts.j_zero) begin
                    o_cmd   = DP_SORT_PLACE;
                    n_state = S_SKEY_RD;
                end else begin
                    o_cmd   = DP_RD_JM1;
                    n_state = S_SCMP_EV;
                end
            end
            S_SCMP_EV: begin
                o_cmd   = DP_SORT_CMP;
                n_state = i_sts.sort_shift ? S_SCMP_RD : S_SKEY_RD;
            end
            S_READ_RD: begin
                if (i_sts.pos_ok) begin
                    o_cmd   = DP_RD_POS;
                    n_state = S_READ_EV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_READ_EV: begin
                o_cmd   = DP_READ_EV;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd   = DP_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: rtl/core/bte_dpath.sv
// Datapath of the table engine: entry RAM, scan counters, accumulators, result register.
`include "bounded_table_engine_defines.svh"

module bte_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bte_pkg::t_dp_cmd    i_cmd,
    output bte_pkg::t_dp_sts    o_sts,
    input  logic [3:0]          i_action,
    input  logic signed [31:0]  i_value,
    input  logic [4:0]          i_position,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [35:0]  o_result_value,
    output logic [4:0]          o_found_position,
    output logic [4:0]          o_match_count,
    output logic [4:0]          o_fill_count,
    output logic                o_is_empty,
    output logic                o_is_full,
    output logic [2:0]          o_status
);
    import bte_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int CW = (IW > 5) ? IW : 5;
    localparam int SW = (33 + IW > 36) ? 33 + IW : 36;

    logic [IW-1:0]        r_fill;
    logic [3:0]           r_act;
    logic signed [31:0]   r_val;
    logic [4:0]           r_pos;
    logic [IW-1:0]        r_i;
    logic [IW-1:0]        r_j;
    logic [IW-1:0]        r_w;
    logic [IW-1:0]        r_fpos;
    logic [IW-1:0]        r_mcnt;
    logic [IW-1:0]        r_cnt;
    logic [IW-1:0]        r_best;
    logic signed [SW-1:0] r_acc;
    logic signed [31:0]   r_key;
    logic signed [35:0]   r_res;
    logic [2:0]           r_st;
    logic                 r_ovalid;
    logic signed [35:0]   r_o_res;
    logic [4:0]           r_o_fpos;
    logic [4:0]           r_o_mcnt;
    logic [4:0]           r_o_fill;
    logic                 r_o_empty;
    logic                 r_o_full;
    logic [2:0]           r_o_st;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [31:0]          wdata;
    logic                 re;
    logic [AW-1:0]        raddr;
    logic [31:0]          rdata;
    logic signed [31:0]   rd_s;
    logic                 match;
    logic                 is_find;
    logic                 is_del;
    logic                 remove;
    logic                 sort_up;
    logic                 sort_shift;
    logic                 out_free;
    logic                 pos_ok;
    logic                 sum_fits;
    logic [SW-36:0]       sum_top;
    logic signed [35:0]   sum_sat;
    logic [IW-1:0]        fill_fin;
    logic [2:0]           st_fin;
    logic signed [35:0]   res_fin;

    bte_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Decode the held action
    assign rd_s       = $signed(rdata);
    assign match      = (rd_s == r_val);
    assign is_del     = (r_act == ACT_DELFIRST) || (r_act == ACT_DELALL);
    assign is_find    = is_del || (r_act == ACT_SEARCH) || (r_act == ACT_COUNT);
    assign remove     = match && ((r_act == ACT_DELALL) ||
                                  ((r_act == ACT_DELFIRST) && (r_fpos == '0)));
    assign sort_up    = (r_act == ACT_SORTUP);
    assign sort_shift = sort_up ? (rd_s > r_key) : (rd_s < r_key);
    assign out_free   = !r_ovalid || i_out_ready;
    assign pos_ok     = (r_pos != 5'd0) && (CW'(r_pos) <= CW'(r_fill));

    // Report status to the sequencer
    always_comb begin
        o_sts.act        = r_act;
        o_sts.i_end      = (r_i >= r_fill);
        o_sts.j_end      = (r_j >= r_fill);
        o_sts.j_zero     = (r_j == '0);
        o_sts.sort_shift = sort_shift;
        o_sts.pos_ok     = pos_ok;
        o_sts.out_free   = out_free;
    end

    // Select the RAM read address
    always_comb begin
        re    = 1'b0;
        raddr = AW'(r_i);
        case (i_cmd)
            DP_RD_I: begin
                re    = 1'b1;
                raddr = AW'(r_i);
            end
            DP_RD_J: begin
                re    = 1'b1;
                raddr = AW'(r_j);
            end
            DP_RD_JM1: begin
                re    = 1'b1;
                raddr = AW'(r_j - IW'(1));
            end
            DP_RD_POS: begin
                re    = 1'b1;
                raddr = AW'(r_pos - 5'd1);
            end
            default: re = 1'b0;
        endcase
    end

    // Select the RAM write
    always_comb begin
        we    = 1'b0;
        waddr = AW'(r_j);
        wdata = r_key;
        case (i_cmd)
            DP_APPLY: begin
                we    = (r_act == ACT_ADD) && (r_fill < IW'(CAPACITY));
                waddr = AW'(r_fill);
                wdata = r_val;
            end
            DP_SCAN: begin
                we    = is_del && !remove;
                waddr = AW'(r_w);
                wdata = rdata;
            end
            DP_SORT_CMP: begin
                we    = 1'b1;
                waddr = AW'(r_j);
                wdata = sort_shift ? rdata : r_key;
            end
            DP_SORT_PLACE: begin
                we    = 1'b1;
                waddr = AW'(r_j);
                wdata = r_key;
            end
            default: we = 1'b0;
        endcase
    end

    // Saturate the sum to the result range
    assign sum_top  = r_acc[SW-1:35];
    assign sum_fits = (&sum_top) || !(|sum_top);
    assign sum_sat  = sum_fits ? r_acc[35:0] :
                      (r_acc[SW-1] ? {1'b1, 35'd0} : {1'b0, {35{1'b1}}});

    // Form the final fill, status and result
    always_comb begin
        fill_fin = is_del ? r_w : r_fill;
        st_fin   = ST_OK;
        res_fin  = '0;
        case (r_act)
            ACT_ADD:                             st_fin = r_st;
            ACT_DELFIRST, ACT_DELALL, ACT_SEARCH:
                st_fin = (r_fpos == '0) ? ST_NOTFOUND : ST_OK;
            ACT_SUM: begin
                st_fin  = (r_fill == '0) ? ST_EMPTY : ST_OK;
                res_fin = sum_sat;
            end
            ACT_MAX, ACT_MIN: begin
                st_fin  = (r_fill == '0) ? ST_EMPTY : ST_OK;
                res_fin = r_acc[35:0];
            end
            ACT_MODE: begin
                st_fin  = (r_fill == '0) ? ST_EMPTY : ST_OK;
                res_fin = r_res;
            end
            ACT_READ: begin
                st_fin  = pos_ok ? ST_OK : ST_RANGE;
                res_fin = r_res;
            end
            default: st_fin = ST_OK;
        endcase
    end

    // Run the datapath commands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready && (i_cmd != DP_FINISH)) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd)
                DP_LOAD: begin
                    r_act  <= i_action;
                    r_val  <= i_value;
                    r_pos  <= i_position;
                    r_i    <= ((i_action == ACT_SORTUP) || (i_action == ACT_SORTDN)) ?
                              IW'(1) : '0;
                    r_w    <= '0;
                    r_fpos <= '0;
                    r_mcnt <= '0;
                    r_best <= '0;
                    r_acc  <= '0;
                    r_res  <= '0;
                    r_st   <= ST_OK;
                end
                DP_APPLY: begin
                    if (r_act == ACT_CLEAR) begin
                        r_fill <= '0;
                    end else if (r_act == ACT_ADD) begin
                        if (r_fill < IW'(CAPACITY)) begin
                            r_fill <= r_fill + IW'(1);
                        end else begin
                            r_st <= ST_FULL;
                        end
                    end
                end
                DP_SCAN: begin
                    if (is_find) begin
                        if (match && (r_fpos == '0)) begin
                            r_fpos <= r_i + IW'(1);
                        end
                        if ((r_act == ACT_COUNT) ? match : remove) begin
                            r_mcnt <= r_mcnt + IW'(1);
                        end
                    end
                    if (!remove) begin
                        r_w <= r_w + IW'(1);
                    end
                    case (r_act)
                        ACT_SUM: r_acc <= r_acc + SW'(rd_s);
                        ACT_MAX: begin
                            if ((r_i == '0) || (rd_s > r_acc)) begin
                                r_acc <= SW'(rd_s);
                            end
                        end
                        ACT_MIN: begin
                            if ((r_i == '0) || (rd_s < r_acc)) begin
                                r_acc <= SW'(rd_s);
                            end
                        end
                        default: r_acc <= r_acc;
                    endcase
                    r_i <= r_i + IW'(1);
                end
                DP_MODE_KEY: begin
                    r_key <= rd_s;
                    r_j   <= '0;
                    r_cnt <= '0;
                end
                DP_MODE_CNT: begin
                    if (rd_s == r_key) begin
                        r_cnt <= r_cnt + IW'(1);
                    end
                    r_j <= r_j + IW'(1);
                end
                DP_MODE_NEXT: begin
                    if (r_cnt > r_best) begin
                        r_best <= r_cnt;
                        r_res  <= 36'(r_key);
                    end
                    r_i <= r_i + IW'(1);
                end
                DP_SORT_KEY: begin
                    r_key <= rd_s;
                    r_j   <= r_i;
                end
                DP_SORT_CMP: begin
                    if (sort_shift) begin
                        r_j <= r_j - IW'(1);
                    end else begin
                        r_i <= r_i + IW'(1);
                    end
                end
                DP_SORT_PLACE: r_i <= r_i + IW'(1);
                DP_READ_EV:    r_res <= 36'(rd_s);
                DP_FINISH: begin
                    r_fill    <= fill_fin;
                    r_ovalid  <= 1'b1;
                    r_o_res   <= res_fin;
                    r_o_fpos  <= is_find ? 5'(r_fpos) : 5'd0;
                    r_o_mcnt  <= is_find ? 5'(r_mcnt) : 5'd0;
                    r_o_fill  <= 5'(fill_fin);
                    r_o_empty <= (fill_fin == '0);
                    r_o_full  <= (fill_fin == IW'(CAPACITY));
                    r_o_st    <= st_fin;
                end
                default: r_fill <= r_fill;
            endcase
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_result_value   = r_o_res;
    assign o_found_position = r_o_fpos;
    assign o_match_count    = r_o_mcnt;
    assign o_fill_count     = r_o_fill;
    assign o_is_empty       = r_o_empty;
    assign o_is_full        = r_o_full;
    assign o_status         = r_o_st;

    // The list never grows past its capacity
    `BTE_ASSERT_ALWAYS(a_fill_cap, i_clk, i_rst_n, r_fill <= IW'(CAPACITY))
    // The compaction writer never overtakes the scan reader
    `BTE_ASSERT_ALWAYS(a_w_le_i, i_clk, i_rst_n, (i_cmd != DP_SCAN) || (r_w <= r_i))
    // A finished action always presents its result
    `BTE_ASSERT_NEXT(a_finish_valid, i_clk, i_rst_n, i_cmd == DP_FINISH, r_ovalid)

endmodule

// File: rtl/core/bounded_table_engine.sv
// Top level of the bounded table engine: sequencer plus datapath.
// Clear, add and undefined actions finish without reading the entries; search, count, delete,
// sum, max and min read each entry once; read reads the addressed entry unless out of range.
// Mode compares each entry against every entry, and sorts shift entries by insertion.
// One transaction at a time; a result held by the receiver stalls the next one.
// Reset clears the fill count and the output valid; entry contents are not cleared.
module bounded_table_engine #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [3:0]         i_action,
    input  logic signed [31:0] i_value,
    input  logic [4:0]         i_position,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [35:0] o_result_value,
    output logic [4:0]         o_found_position,
    output logic [4:0]         o_match_count,
    output logic [4:0]         o_fill_count,
    output logic               o_is_empty,
    output logic               o_is_full,
    output logic [2:0]         o_status
);
    import bte_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    bte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bte_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_action         (i_action),
        .i_value          (i_value),
        .i_position       (i_position),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_value   (o_result_value),
        .o_found_position (o_found_position),
        .o_match_count    (o_match_count),
        .o_fill_count     (o_fill_count),
        .o_is_empty       (o_is_empty),
        .o_is_full        (o_is_full),
        .o_status         (o_status)
    );

endmodule

// File: tb/bte_checker.sv
// Checker for the table engine: predicts every result and compares the outputs.
`timescale 1ns / 100ps
module bte_checker #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [3:0]         i_action,
    input  logic signed [31:0] i_value,
    input  logic [4:0]         i_position,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [35:0] i_result_value,
    input  logic [4:0]         i_found_position,
    input  logic [4:0]         i_match_count,
    input  logic [4:0]         i_fill_count,
    input  logic               i_is_empty,
    input  logic               i_is_full,
    input  logic [2:0]         i_status,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results_seen
);
    import bte_pkg::*;

    typedef struct packed {
        logic signed [35:0] result_value;
        logic [4:0]         found_position;
        logic [4:0]         match_count;
        logic [4:0]         fill_count;
        logic               is_empty;
        logic               is_full;
        logic [2:0]         status;
    } t_table_result;

    logic signed [31:0] list_q [CAPACITY];
    int                 list_fill;
    t_table_result      expected_q [$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic int first_pos(input logic signed [31:0] v);
        for (int i = 0; i < list_fill; i++)
            if (list_q[i] == v) return i + 1;
        return 0;
    endfunction

    function automatic int num_equal(input logic signed [31:0] v);
        int c;
        c = 0;
        for (int i = 0; i < list_fill; i++)
            if (list_q[i] == v) c++;
        return c;
    endfunction

    // Apply one action to the shadow list and build its result.
    function automatic t_table_result apply_action(input logic [3:0] act,
                                                   input logic signed [31:0] v,
                                                   input logic [4:0] pos);
        t_table_result r;
        longint acc;
        int fp, mc, w, best, c, j;
        logic signed [31:0] key;
        bit up;
        r = '0;
        acc = 0;
        fp = 0;
        mc = 0;
        case (act)
            ACT_CLEAR: list_fill = 0;
            ACT_ADD: begin
                if (list_fill >= CAPACITY) r.status = ST_FULL;
                else begin
                    list_q[list_fill] = v;
                    list_fill++;
                end
            end
            ACT_DELFIRST: begin
                fp = first_pos(v);
                if (fp == 0) r.status = ST_NOTFOUND;
                else begin
                    for (int i = fp - 1; i + 1 < list_fill; i++) list_q[i] = list_q[i + 1];
                    list_fill--;
                    mc = 1;
                end
            end
            ACT_DELALL: begin
                fp = first_pos(v);
                if (fp == 0) r.status = ST_NOTFOUND;
                else begin
                    w = 0;
                    for (int i = 0; i < list_fill; i++) begin
                        if (list_q[i] == v) mc++;
                        else begin
                            list_q[w] = list_q[i];
                            w++;
                        end
                    end
                    list_fill = w;
                end
            end
            ACT_SEARCH: begin
                fp = first_pos(v);
                if (fp == 0) r.status = ST_NOTFOUND;
            end
            ACT_COUNT: begin
                fp = first_pos(v);
                mc = num_equal(v);
            end
            ACT_SUM, ACT_MAX, ACT_MIN, ACT_MODE: begin
                if (list_fill == 0) r.status = ST_EMPTY;
                else if (act == ACT_SUM) begin
                    for (int i = 0; i < list_fill; i++) acc += list_q[i];
                    if (acc > 64'sd34359738367) acc = 64'sd34359738367;
                    if (acc < -64'sd34359738368) acc = -64'sd34359738368;
                end else if (act == ACT_MAX) begin
                    acc = list_q[0];
                    for (int i = 1; i < list_fill; i++) if (list_q[i] > acc) acc = list_q[i];
                end else if (act == ACT_MIN) begin
                    acc = list_q[0];
                    for (int i = 1; i < list_fill; i++) if (list_q[i] < acc) acc = list_q[i];
                end else begin
                    best = num_equal(list_q[0]);
                    acc = list_q[0];
                    for (int i = 1; i < list_fill; i++) begin
                        c = num_equal(list_q[i]);
                        if (c > best) begin
                            best = c;
                            acc = list_q[i];
                        end
                    end
                end
            end
            ACT_SORTUP, ACT_SORTDN: begin
                // Insertion sort, same order of moves as the block's passes.
                up = (act == ACT_SORTUP);
                for (int i = 1; i < list_fill; i++) begin
                    key = list_q[i];
                    j = i;
                    while (j > 0 && (up ? list_q[j - 1] > key : list_q[j - 1] < key)) begin
                        list_q[j] = list_q[j - 1];
                        j--;
                    end
                    list_q[j] = key;
                end
            end
            ACT_READ: begin
                if (pos == 0 || pos > list_fill) r.status = ST_RANGE;
                else acc = list_q[pos - 1];
            end
            default: ;
        endcase
        r.result_value   = acc[35:0];
        r.found_position = fp[4:0];
        r.match_count    = mc[4:0];
        r.fill_count     = list_fill[4:0];
        r.is_empty       = (list_fill == 0);
        r.is_full        = (list_fill == CAPACITY);
        return r;
    endfunction

    // Predict on accepted inputs, compare on accepted outputs.
    always @(posedge i_clk) begin
        t_table_result want;
        if (!i_rst_n) begin
            list_fill = 0;
            expected_q.delete();
            o_fail_count = 0;
            o_results_seen = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_results_seen++;
                if (expected_q.size() == 0)
                    report_mismatch("unexpected transaction", 0, 0);
                else begin
                    want = expected_q.pop_front();
                    if (i_result_value !== want.result_value)
                        report_mismatch("result_value", i_result_value, want.result_value);
                    if (i_found_position !== want.found_position)
                        report_mismatch("found_position", i_found_position,
                                        want.found_position);
                    if (i_match_count !== want.match_count)
                        report_mismatch("match_count", i_match_count, want.match_count);
                    if (i_fill_count !== want.fill_count)
                        report_mismatch("fill_count", i_fill_count, want.fill_count);
                    if (i_is_empty !== want.is_empty)
                        report_mismatch("is_empty", i_is_empty, want.is_empty);
                    if (i_is_full !== want.is_full)
                        report_mismatch("is_full", i_is_full, want.is_full);
                    if (i_status !== want.status)
                        report_mismatch("status", i_status, want.status);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_q.push_back(apply_action(i_action, i_value, i_position));
        end
        o_pending = expected_q.size();
    end

endmodule

// File: tb/tb_top.sv
// Top of the table engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
    import bte_pkg::*;

    localparam int CAPACITY  = 16;
    localparam int IDLE_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [3:0]         action;
    logic signed [31:0] value;
    logic [4:0]         position;
    logic               out_valid;
    logic               out_ready;
    logic signed [35:0] result_value;
    logic [4:0]         found_position;
    logic [4:0]         match_count;
    logic [4:0]         fill_count;
    logic               is_empty;
    logic               is_full;
    logic [2:0]         status;
    int                 fail_count;
    int                 pending;
    int                 results_seen;
    int                 items_sent;
    int                 idle_cycles;
    bit                 calm;
    bit                 hold_off;
    logic signed [31:0] pool [8];

    bounded_table_engine #(.CAPACITY(CAPACITY)) uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_action(action), .i_value(value), .i_position(position),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_result_value(result_value), .o_found_position(found_position),
        .o_match_count(match_count), .o_fill_count(fill_count),
        .o_is_empty(is_empty), .o_is_full(is_full), .o_status(status)
    );

    bte_checker #(.CAPACITY(CAPACITY)) checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_action(action), .i_value(value), .i_position(position),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_result_value(result_value), .i_found_position(found_position),
        .i_match_count(match_count), .i_fill_count(fill_count),
        .i_is_empty(is_empty), .i_is_full(is_full), .i_status(status),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Send one transaction, idling first now and then; hold until accepted.
    task automatic send_item(input logic [3:0] act, input logic signed [31:0] v,
                             input logic [4:0] pos);
        while (!calm && $urandom_range(99) < 6) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        value    <= v;
        position <= pos;
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom();
            default: return pool[$urandom_range(7)];
        endcase
    endfunction

    // Receiver: random stalls, one long hold-off, no stalls during calm stretch.
    always @(negedge clk) begin
        if (!rst_n) out_ready <= 1'b0;
        else if (hold_off) out_ready <= 1'b0;
        else out_ready <= calm || ($urandom_range(99) >= 6);
    end

    initial begin
        hold_off = 1'b0;
        wait (items_sent == 600);
        hold_off = 1'b1;
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
    end

    // Stall watchdog.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int n;
        logic [3:0] act;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_CLEAR;
        value = '0;
        position = '0;
        calm = 1'b0;
        items_sent = 0;
        pool[0] = 32'sh7fffffff;
        pool[1] = 32'sh80000000;
        pool[2] = 0;
        pool[3] = -1;
        for (int i = 4; i < 8; i++) pool[i] = $urandom();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty-list cases, extremes, full list, every action.
        send_item(ACT_SUM, 0, 1);
        send_item(ACT_MODE, 0, 1);
        send_item(ACT_SEARCH, 5, 1);
        send_item(ACT_DELFIRST, 5, 1);
        send_item(ACT_READ, 0, 1);
        send_item(ACT_SORTUP, 0, 0);
        send_item(ACT_COUNT, 5, 0);
        for (int i = 0; i < CAPACITY; i++)
            send_item(ACT_ADD, (i % 3 == 0) ? 32'sh80000000 : 32'sh7fffffff, 0);
        send_item(ACT_ADD, 7, 0);
        send_item(ACT_SUM, 0, 0);
        send_item(ACT_MAX, 0, 0);
        send_item(ACT_MIN, 0, 0);
        send_item(ACT_MODE, 0, 0);
        send_item(ACT_READ, 0, 5'd16);
        send_item(ACT_READ, 0, 5'd0);
        send_item(ACT_READ, 0, 5'd31);
        send_item(ACT_SORTDN, 0, 0);
        send_item(ACT_DELALL, 32'sh80000000, 0);
        send_item(ACT_DELFIRST, 32'sh7fffffff, 0);
        send_item(ACT_SORTUP, 0, 0);
        send_item(4'd13, -1, 5'd31);
        send_item(4'd15, 0, 0);
        send_item(ACT_CLEAR, 0, 0);

        // Random: fill phases with repeated values, then mixed actions.
        n = 0;
        while (n < 1950) begin
            calm = (n >= 1200 && n < 1400);
            if ($urandom_range(9) == 0) begin
                send_item(ACT_CLEAR, $urandom(), 5'($urandom()));
                n++;
            end
            for (int k = $urandom_range(CAPACITY + 2); k > 0; k--) begin
                send_item(ACT_ADD, pick_value(), 5'($urandom()));
                n++;
            end
            for (int k = $urandom_range(8); k > 0; k--) begin
                act = 4'($urandom_range(15));
                if (act == ACT_CLEAR) act = ACT_READ;
                send_item(act, pick_value(),
                          ($urandom_range(3) == 0) ? 5'($urandom()) :
                                                     5'($urandom_range(1, 16)));
                n++;
            end
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (600) @(posedge clk);
        $display("Sent %0d transactions over all actions, full and empty lists,", items_sent);
        $display("checked %0d results under random stalls and one long hold-off.",
                 results_seen);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
